// ===== sv/bcpe_pkg.sv =====
// ----------------------------------------------------------------------------
// bcpe_pkg
// Shared types and constants of the Bezier curve point evaluator.
// ----------------------------------------------------------------------------
`default_nettype none

package bcpe_pkg;

  localparam int MAX_POINTS_DEF = 32;

  localparam logic [31:0] RADIUS_RESET = 32'd10737418;
  localparam logic [16:0] T_ONE        = 17'd65536;

  localparam logic [1:0] KIND_CLEAR  = 2'd0;
  localparam logic [1:0] KIND_APPEND = 2'd1;
  localparam logic [1:0] KIND_REMOVE = 2'd2;
  localparam logic [1:0] KIND_EVAL   = 2'd3;

  localparam logic [2:0] ST_OK      = 3'd0;
  localparam logic [2:0] ST_TOO_FEW = 3'd1;
  localparam logic [2:0] ST_FULL    = 3'd2;
  localparam logic [2:0] ST_DUP     = 3'd3;
  localparam logic [2:0] ST_NONE    = 3'd4;

  // Broadcast from the controller to every cell.
  typedef struct packed {
    logic [1:0]         kind;
    logic               load;
    logic               step;
    logic               write;
    logic               shift;
    logic signed [15:0] qx;
    logic signed [15:0] qy;
    logic [16:0]        t;
    logic [31:0]        radius;
  } ctl_t;

  // Search token that travels one cell per cycle.
  typedef struct packed {
    logic valid;
    logic dup;
    logic hit;
  } tok_t;

endpackage

`default_nettype wire

// ===== sv/bezier_curve_point_evaluator_core.sv =====
// ----------------------------------------------------------------------------
// bezier_curve_point_evaluator_core
// Stores up to MaxPoints control points in a row of cells and evaluates the
// Bezier curve through them by de Casteljau steps across the row.
// ----------------------------------------------------------------------------
//  channel   direction  handshake               payload
//  in        input      in_valid_i / in_stall_o  kind, point_x, point_y, curve_t
//  out       output     out_valid_o / out_stall_i curve_x, curve_y, status
//  cfg       input      cfg_we_i                 cfg_wdata_i (remove radius squared)
//
// Clear and too-few evaluate go straight to the done state.
// Append and remove wait in the scan state while the search token walks the row.
// Evaluate makes one shared step of all cells per level.
// Reset empties the list and sets the squared radius to RADIUS_RESET; no clearing pass.
// A stalled output holds the block in its final state until the output register is free.
`default_nettype none

module bezier_curve_point_evaluator_core #(
  parameter int MaxPoints = bcpe_pkg::MAX_POINTS_DEF
) (
  input  wire                clk_i,
  input  wire                rst_ni,
  input  wire                in_valid_i,
  output logic               in_stall_o,
  input  wire [1:0]          kind_i,
  input  wire signed [15:0]  point_x_i,
  input  wire signed [15:0]  point_y_i,
  input  wire [16:0]         curve_t_i,
  input  wire                cfg_we_i,
  input  wire [31:0]         cfg_wdata_i,
  output logic               out_valid_o,
  input  wire                out_stall_i,
  output logic signed [15:0] curve_x_o,
  output logic signed [15:0] curve_y_o,
  output logic [2:0]         status_o
);
  import bcpe_pkg::*;

  localparam int CntW = $clog2(MaxPoints + 1);

  ctl_t               ctl;
  logic [CntW-1:0]    count;
  tok_t               tok [0:MaxPoints];
  logic signed [15:0] pt_x [0:MaxPoints];
  logic signed [15:0] pt_y [0:MaxPoints];
  logic signed [31:0] w_x  [0:MaxPoints];
  logic signed [31:0] w_y  [0:MaxPoints];

  // Past the last cell there is no neighbor.
  assign pt_x[MaxPoints] = '0;
  assign pt_y[MaxPoints] = '0;
  assign w_x[MaxPoints]  = '0;
  assign w_y[MaxPoints]  = '0;

  bcpe_ctrl #(
    .MaxPoints (MaxPoints),
    .CntW      (CntW)
  ) u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .kind_i      (kind_i),
    .point_x_i   (point_x_i),
    .point_y_i   (point_y_i),
    .curve_t_i   (curve_t_i),
    .cfg_we_i    (cfg_we_i),
    .cfg_wdata_i (cfg_wdata_i),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .curve_x_o   (curve_x_o),
    .curve_y_o   (curve_y_o),
    .status_o    (status_o),
    .ctl_o       (ctl),
    .count_o     (count),
    .tok_o       (tok[0]),
    .tok_i       (tok[MaxPoints]),
    .w0_x_i      (w_x[0]),
    .w0_y_i      (w_y[0])
  );

  for (genvar k = 0; k < MaxPoints; k++) begin : g_cell
    bcpe_cell #(
      .CntW (CntW),
      .K    (k)
    ) u_cell (
      .clk_i     (clk_i),
      .rst_ni    (rst_ni),
      .ctl_i     (ctl),
      .count_i   (count),
      .nb_pt_x_i (pt_x[k+1]),
      .nb_pt_y_i (pt_y[k+1]),
      .nb_w_x_i  (w_x[k+1]),
      .nb_w_y_i  (w_y[k+1]),
      .tok_i     (tok[k]),
      .tok_o     (tok[k+1]),
      .pt_x_o    (pt_x[k]),
      .pt_y_o    (pt_y[k]),
      .w_x_o     (w_x[k]),
      .w_y_o     (w_y[k])
    );
  end

endmodule

`default_nettype wire

// ===== sv/bcpe_cell.sv =====
// ----------------------------------------------------------------------------
// bcpe_cell
// One control point slot: holds a point and a de Casteljau working value,
// checks the passing search token and interpolates toward its neighbor.
// ----------------------------------------------------------------------------
`default_nettype none

module bcpe_cell #(
  parameter int CntW = 6,
  parameter int K    = 0
) (
  input  wire                  clk_i,
  input  wire                  rst_ni,
  input  bcpe_pkg::ctl_t       ctl_i,
  input  wire [CntW-1:0]       count_i,
  input  wire signed [15:0]    nb_pt_x_i,
  input  wire signed [15:0]    nb_pt_y_i,
  input  wire signed [31:0]    nb_w_x_i,
  input  wire signed [31:0]    nb_w_y_i,
  input  bcpe_pkg::tok_t       tok_i,
  output bcpe_pkg::tok_t       tok_o,
  output logic signed [15:0]   pt_x_o,
  output logic signed [15:0]   pt_y_o,
  output logic signed [31:0]   w_x_o,
  output logic signed [31:0]   w_y_o
);
  import bcpe_pkg::*;

  localparam logic [CntW-1:0] KIdx = CntW'(K);

  logic signed [15:0] pt_x_q, pt_y_q;
  logic signed [31:0] w_x_q, w_y_q, w_x_d, w_y_d;
  tok_t               tok_q;
  logic               sh_q;

  logic               active, own_dup, own_hit, near;
  logic signed [16:0] dx, dy;
  logic signed [33:0] sqx, sqy;
  logic [34:0]        sq_sum;

  assign active = KIdx < count_i;
  assign dx     = 17'(pt_x_q) - 17'(ctl_i.qx);
  assign dy     = 17'(pt_y_q) - 17'(ctl_i.qy);
  assign sqx    = dx * dx;
  assign sqy    = dy * dy;
  assign sq_sum = 35'(unsigned'(sqx)) + 35'(unsigned'(sqy));
  assign near   = sq_sum <= 35'(ctl_i.radius);

  assign own_dup = active && (ctl_i.kind == KIND_APPEND) &&
                   (pt_x_q == ctl_i.qx) && (pt_y_q == ctl_i.qy);
  assign own_hit = active && (ctl_i.kind == KIND_REMOVE) && near && !tok_i.hit;

  // One interpolation step: a*(1-t) + b*t = a + (b-a)*t, rounded to nearest.
  function automatic logic signed [31:0] lerp(logic signed [31:0] a,
                                              logic signed [31:0] b,
                                              logic [16:0] t);
    logic signed [32:0] diff;
    logic signed [50:0] prod;
    logic signed [50:0] sum;
    diff = 33'(b) - 33'(a);
    prod = diff * $signed({1'b0, t});
    sum  = {{3{a[31]}}, a, 16'd0} + prod + 51'sd32768;
    return sum[47:16];
  endfunction

  assign w_x_d = lerp(w_x_q, nb_w_x_i, ctl_i.t);
  assign w_y_d = lerp(w_y_q, nb_w_y_i, ctl_i.t);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      tok_q <= '0;
      sh_q  <= 1'b0;
    end else begin
      tok_q.valid <= tok_i.valid;
      tok_q.dup   <= tok_i.valid & (tok_i.dup | own_dup);
      tok_q.hit   <= tok_i.valid & (tok_i.hit | own_hit);
      // A cell at or after the removed point takes its neighbor's point.
      if (tok_i.valid) begin
        sh_q <= tok_i.hit | own_hit;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (ctl_i.write && (KIdx == count_i)) begin
      pt_x_q <= ctl_i.qx;
      pt_y_q <= ctl_i.qy;
    end else if (ctl_i.shift && sh_q) begin
      pt_x_q <= nb_pt_x_i;
      pt_y_q <= nb_pt_y_i;
    end
    if (ctl_i.load) begin
      w_x_q <= {{1{pt_x_q[15]}}, pt_x_q, 15'd0};
      w_y_q <= {{1{pt_y_q[15]}}, pt_y_q, 15'd0};
    end else if (ctl_i.step) begin
      w_x_q <= w_x_d;
      w_y_q <= w_y_d;
    end
  end

  assign tok_o  = tok_q;
  assign pt_x_o = pt_x_q;
  assign pt_y_o = pt_y_q;
  assign w_x_o  = w_x_q;
  assign w_y_o  = w_y_q;

endmodule

`default_nettype wire

// ===== sv/bcpe_ctrl.sv =====
// ----------------------------------------------------------------------------
// bcpe_ctrl
// Sequencer of the evaluator: accepts transactions, drives the cell row,
// keeps the point count and the radius register, and holds the result.
// ----------------------------------------------------------------------------
`default_nettype none

module bcpe_ctrl #(
  parameter int MaxPoints = bcpe_pkg::MAX_POINTS_DEF,
  parameter int CntW      = $clog2(MaxPoints + 1)
) (
  input  wire                 clk_i,
  input  wire                 rst_ni,
  input  wire                 in_valid_i,
  output logic                in_stall_o,
  input  wire [1:0]           kind_i,
  input  wire signed [15:0]   point_x_i,
  input  wire signed [15:0]   point_y_i,
  input  wire [16:0]          curve_t_i,
  input  wire                 cfg_we_i,
  input  wire [31:0]          cfg_wdata_i,
  output logic                out_valid_o,
  input  wire                 out_stall_i,
  output logic signed [15:0]  curve_x_o,
  output logic signed [15:0]  curve_y_o,
  output logic [2:0]          status_o,
  output bcpe_pkg::ctl_t      ctl_o,
  output logic [CntW-1:0]     count_o,
  output bcpe_pkg::tok_t      tok_o,
  input  bcpe_pkg::tok_t      tok_i,
  input  wire signed [31:0]   w0_x_i,
  input  wire signed [31:0]   w0_y_i
);
  import bcpe_pkg::*;

  localparam logic [2:0] S_IDLE = 3'd0;
  localparam logic [2:0] S_SCAN = 3'd1;
  localparam logic [2:0] S_EVAL = 3'd2;
  localparam logic [2:0] S_FIN  = 3'd3;
  localparam logic [2:0] S_DONE = 3'd4;

  localparam logic [CntW-1:0] CntMax = CntW'(MaxPoints);
  localparam logic [CntW-1:0] CntOne = CntW'(1);
  localparam logic [CntW-1:0] CntTwo = CntW'(2);

  logic [2:0]         state_q, state_d;
  logic [CntW-1:0]    count_q, count_d, lvl_q, lvl_d;
  logic [1:0]         kind_q;
  logic signed [15:0] qx_q, qy_q;
  logic [16:0]        t_q;
  logic [31:0]        radius_q;
  logic signed [15:0] res_x_q, res_x_d, res_y_q, res_y_d;
  logic [2:0]         res_st_q, res_st_d;
  logic               out_valid_q;
  logic signed [15:0] out_x_q, out_y_q;
  logic [2:0]         out_st_q;
  logic               accept, out_free, do_write, do_shift, do_load, do_step;
  logic signed [15:0] fin_x, fin_y;

  function automatic logic signed [15:0] round_out(logic signed [31:0] w);
    logic signed [32:0] v;
    logic signed [17:0] r;
    v = 33'(w) + 33'sd16384;
    r = 18'(v >>> 15);
    if (r > 18'sd32767) return 16'sd32767;
    if (r < -18'sd32768) return -16'sd32768;
    return r[15:0];
  endfunction

  assign in_stall_o = state_q != S_IDLE;
  assign accept     = in_valid_i && !in_stall_o;
  assign out_free   = !out_valid_q || !out_stall_i;
  assign fin_x      = round_out(w0_x_i);
  assign fin_y      = round_out(w0_y_i);

  always_comb begin
    state_d  = state_q;
    count_d  = count_q;
    lvl_d    = lvl_q;
    res_x_d  = res_x_q;
    res_y_d  = res_y_q;
    res_st_d = res_st_q;
    do_write = 1'b0;
    do_shift = 1'b0;
    do_load  = 1'b0;
    do_step  = 1'b0;
    case (state_q)
      S_IDLE: begin
        if (accept) begin
          res_x_d  = '0;
          res_y_d  = '0;
          res_st_d = ST_OK;
          case (kind_i)
            KIND_CLEAR: begin
              count_d = '0;
              state_d = S_DONE;
            end
            KIND_EVAL: begin
              if (count_q < CntTwo) begin
                res_st_d = ST_TOO_FEW;
                state_d  = S_DONE;
              end else begin
                do_load = 1'b1;
                lvl_d   = count_q - CntOne;
                state_d = S_EVAL;
              end
            end
            default: state_d = S_SCAN;
          endcase
        end
      end
      S_SCAN: begin
        if (tok_i.valid) begin
          state_d = S_DONE;
          if (kind_q == KIND_APPEND) begin
            if (tok_i.dup) begin
              res_st_d = ST_DUP;
            end else if (count_q == CntMax) begin
              res_st_d = ST_FULL;
            end else begin
              do_write = 1'b1;
              count_d  = count_q + CntOne;
            end
          end else if (tok_i.hit) begin
            do_shift = 1'b1;
            count_d  = count_q - CntOne;
          end else begin
            res_st_d = ST_NONE;
          end
        end
      end
      S_EVAL: begin
        do_step = 1'b1;
        lvl_d   = lvl_q - CntOne;
        if (lvl_q == CntOne) begin
          state_d = S_FIN;
        end
      end
      S_FIN: begin
        res_x_d = fin_x;
        res_y_d = fin_y;
        state_d = S_DONE;
      end
      S_DONE: begin
        if (out_free) begin
          state_d = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      count_q     <= '0;
      lvl_q       <= '0;
      radius_q    <= RADIUS_RESET;
      out_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      count_q <= count_d;
      lvl_q   <= lvl_d;
      if (cfg_we_i) begin
        radius_q <= cfg_wdata_i;
      end
      if (state_q == S_DONE && out_free) begin
        out_valid_q <= 1'b1;
      end else if (!out_stall_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    res_x_q  <= res_x_d;
    res_y_q  <= res_y_d;
    res_st_q <= res_st_d;
    if (accept) begin
      kind_q <= kind_i;
      qx_q   <= point_x_i;
      qy_q   <= point_y_i;
      t_q    <= (curve_t_i > T_ONE) ? T_ONE : curve_t_i;
    end
    if (state_q == S_DONE && out_free) begin
      out_x_q  <= res_x_q;
      out_y_q  <= res_y_q;
      out_st_q <= res_st_q;
    end
  end

  always_comb begin
    ctl_o.kind   = kind_q;
    ctl_o.load   = do_load;
    ctl_o.step   = do_step;
    ctl_o.write  = do_write;
    ctl_o.shift  = do_shift;
    ctl_o.qx     = qx_q;
    ctl_o.qy     = qy_q;
    ctl_o.t      = t_q;
    ctl_o.radius = radius_q;
  end

  // The token enters the first cell in the cycle after an append or remove is accepted.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      tok_o <= '0;
    end else begin
      tok_o.valid <= accept && (kind_i == KIND_APPEND || kind_i == KIND_REMOVE);
      tok_o.dup   <= 1'b0;
      tok_o.hit   <= 1'b0;
    end
  end

  assign count_o     = count_q;
  assign out_valid_o = out_valid_q;
  assign curve_x_o   = out_x_q;
  assign curve_y_o   = out_y_q;
  assign status_o    = out_st_q;

  a_count_max: assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= CntMax) else $error("point count above capacity");
  a_tok_scan: assert property (@(posedge clk_i) disable iff (!rst_ni)
    tok_i.valid |-> state_q == S_SCAN) else $error("token returned outside a scan");
  a_write_room: assert property (@(posedge clk_i) disable iff (!rst_ni)
    do_write |-> count_q < CntMax && !do_shift) else $error("write into a full row");
  a_eval_levels: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == S_EVAL |-> lvl_q != '0) else $error("evaluation without levels left");

endmodule

`default_nettype wire

// ===== tb/bcpe_checker.sv =====
// ----------------------------------------------------------------------------
// bcpe_checker
// Watches the in, out and cfg channels of the Bezier curve point evaluator, predicts each
// result from a private copy of the point list and radius, and counts mismatches.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module bcpe_checker (
  input  wire               clk_i,
  input  wire               rst_ni,
  input  wire               in_valid_i,
  input  wire               in_stall_i,
  input  wire [1:0]         kind_i,
  input  wire signed [15:0] point_x_i,
  input  wire signed [15:0] point_y_i,
  input  wire [16:0]        curve_t_i,
  input  wire               cfg_we_i,
  input  wire [31:0]        cfg_wdata_i,
  input  wire               out_valid_i,
  input  wire               out_stall_i,
  input  wire signed [15:0] curve_x_i,
  input  wire signed [15:0] curve_y_i,
  input  wire [2:0]         status_i,
  output int                fail_count_o,
  output int                pending_o
);
  import bcpe_pkg::*;

  typedef struct packed {
    logic signed [15:0] x;
    logic signed [15:0] y;
    logic [2:0]         status;
  } curve_result_t;

  logic signed [15:0] ctrl_x [MAX_POINTS_DEF];
  logic signed [15:0] ctrl_y [MAX_POINTS_DEF];
  int                 num_points;
  logic [31:0]        pick_radius_sq;
  curve_result_t      expected_results [$];

  function automatic longint floor_div(longint v, int s);
    return v >>> s;  // arithmetic shift on longint is a floor division
  endfunction

  function automatic logic signed [15:0] sat16(longint v);
    if (v > 32767) return 16'sd32767;
    if (v < -32768) return -16'sd32768;
    return v[15:0];
  endfunction

  function automatic curve_result_t apply_command(logic [1:0] kind, logic signed [15:0] px,
                                                  logic signed [15:0] py, logic [16:0] t);
    curve_result_t r;
    longint wx [MAX_POINTS_DEF];
    longint wy [MAX_POINTS_DEF];
    longint tt, uu, dx, dy;
    logic [63:0] sq_dist;
    bit dup;
    r = '0;
    r.status = ST_OK;
    case (kind)
      KIND_CLEAR: num_points = 0;
      KIND_APPEND: begin
        dup = 0;
        for (int i = 0; i < num_points; i++)
          if (ctrl_x[i] == px && ctrl_y[i] == py) dup = 1;
        if (dup) r.status = ST_DUP;
        else if (num_points >= MAX_POINTS_DEF) r.status = ST_FULL;
        else begin
          ctrl_x[num_points] = px;
          ctrl_y[num_points] = py;
          num_points++;
        end
      end
      KIND_REMOVE: begin
        r.status = ST_NONE;
        for (int i = 0; i < num_points; i++) begin
          dx = longint'(ctrl_x[i]) - longint'(px);
          dy = longint'(ctrl_y[i]) - longint'(py);
          sq_dist = dx * dx + dy * dy;
          if (sq_dist <= {32'd0, pick_radius_sq}) begin
            for (int k = i; k + 1 < num_points; k++) begin
              ctrl_x[k] = ctrl_x[k + 1];
              ctrl_y[k] = ctrl_y[k + 1];
            end
            num_points--;
            r.status = ST_OK;
            break;
          end
        end
      end
      default: begin
        if (num_points < 2) r.status = ST_TOO_FEW;
        else begin
          tt = (t > T_ONE) ? longint'(T_ONE) : longint'(t);
          uu = longint'(T_ONE) - tt;
          for (int i = 0; i < num_points; i++) begin
            wx[i] = longint'(ctrl_x[i]) * 32768;
            wy[i] = longint'(ctrl_y[i]) * 32768;
          end
          for (int k = num_points - 1; k >= 1; k--)
            for (int i = 0; i < k; i++) begin
              wx[i] = floor_div(wx[i] * uu + wx[i + 1] * tt + 32768, 16);
              wy[i] = floor_div(wy[i] * uu + wy[i + 1] * tt + 32768, 16);
            end
          r.x = sat16(floor_div(wx[0] + 16384, 15));
          r.y = sat16(floor_div(wy[0] + 16384, 15));
        end
      end
    endcase
    return r;
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin
    curve_result_t want;
    curve_result_t got;
    if (!rst_ni) begin
      num_points     = 0;
      pick_radius_sq = RADIUS_RESET;
      fail_count_o   = 0;
      expected_results.delete();
      pending_o      = 0;
    end else begin
      if (cfg_we_i) pick_radius_sq = cfg_wdata_i;
      if (in_valid_i && !in_stall_i)
        expected_results.insert(expected_results.size(),
                                apply_command(kind_i, point_x_i, point_y_i, curve_t_i));
      if (out_valid_i && !out_stall_i) begin
        got = '{curve_x_i, curve_y_i, status_i};
        if (expected_results.size() == 0) begin
          fail_count_o++;
          if (fail_count_o <= 10)
            $display("unexpected result x=%0d y=%0d status=%0d", curve_x_i, curve_y_i,
                     status_i);
        end else begin
          want = expected_results.pop_front();
          if (got !== want) begin
            fail_count_o++;
            if (fail_count_o <= 10)
              $display({"result differs: expected x=%0d y=%0d status=%0d, ",
                        "got x=%0d y=%0d status=%0d"},
                       want.x, want.y, want.status, got.x, got.y, got.status);
          end
        end
      end
      pending_o = expected_results.size();
    end
  end

endmodule

`default_nettype wire

// ===== tb/tb_top.sv =====
// ----------------------------------------------------------------------------
// tb_top
// Drives append, remove, clear and evaluate transactions with random idling
// into the Bezier curve point evaluator, varies the pick radius between phases
// and reports the verdict from the checker.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module tb_top;
  import bcpe_pkg::*;

  logic               clk_i = 1'b0;
  logic               rst_ni = 1'b0;
  logic               in_valid_i = 1'b0;
  logic               in_stall_o;
  logic [1:0]         kind_i = KIND_CLEAR;
  logic signed [15:0] point_x_i = '0;
  logic signed [15:0] point_y_i = '0;
  logic [16:0]        curve_t_i = '0;
  logic               cfg_we_i = 1'b0;
  logic [31:0]        cfg_wdata_i = '0;
  logic               out_valid_o;
  logic               out_stall_i = 1'b0;
  logic signed [15:0] curve_x_o;
  logic signed [15:0] curve_y_o;
  logic [2:0]         status_o;
  int                 fail_count;
  int                 pending;

  bit idle_on = 1'b1;   // random idling enabled
  int hold_off = 0;     // cycles of forced receiver stall still to come

  // Points recently appended, so that removes and duplicates hit often.
  logic signed [15:0] known_x [$];
  logic signed [15:0] known_y [$];

  always #4 clk_i = ~clk_i;

  bezier_curve_point_evaluator_core uut (.*);

  bcpe_checker checker_i (
    .clk_i, .rst_ni, .in_valid_i, .in_stall_i(in_stall_o), .kind_i, .point_x_i,
    .point_y_i, .curve_t_i, .cfg_we_i, .cfg_wdata_i, .out_valid_i(out_valid_o),
    .out_stall_i, .curve_x_i(curve_x_o), .curve_y_i(curve_y_o), .status_i(status_o),
    .fail_count_o(fail_count), .pending_o(pending));

  // Receiver stall: random bursts, plus a long hold-off when requested.
  initial begin
    forever begin
      @(negedge clk_i);
      if (hold_off > 0) begin
        out_stall_i <= 1'b1;
        hold_off--;
      end else if (idle_on && $urandom_range(0, 9) == 0) begin
        out_stall_i <= 1'b1;
        repeat ($urandom_range(1, 17) - 1) @(negedge clk_i);
      end else begin
        out_stall_i <= 1'b0;
      end
    end
  end

  // Valid stays high after a transaction until the next one or an idle gap.
  task automatic send_item(logic [1:0] kind, logic signed [15:0] px, logic signed [15:0] py,
                           logic [16:0] t);
    if (idle_on && $urandom_range(0, 7) == 0) begin
      in_valid_i <= 1'b0;
      repeat ($urandom_range(1, 17)) @(negedge clk_i);
    end
    in_valid_i <= 1'b1;
    kind_i     <= kind;
    point_x_i  <= px;
    point_y_i  <= py;
    curve_t_i  <= t;
    if (kind == KIND_APPEND) begin
      known_x.insert(known_x.size(), px);
      known_y.insert(known_y.size(), py);
      if (known_x.size() > 40) begin
        void'(known_x.pop_front());
        void'(known_y.pop_front());
      end
    end
    @(posedge clk_i);
    while (in_stall_o) @(posedge clk_i);
    @(negedge clk_i);
  endtask

  task automatic drain_results();
    in_valid_i <= 1'b0;
    while (pending != 0) @(negedge clk_i);
    repeat (40) @(negedge clk_i);
  endtask

  task automatic write_radius(logic [31:0] value);
    drain_results();
    cfg_we_i    <= 1'b1;
    cfg_wdata_i <= value;
    @(negedge clk_i);
    cfg_we_i    <= 1'b0;
  endtask

  task automatic random_item();
    int sel;
    int j;
    logic signed [15:0] px, py;
    logic [16:0] t;
    sel = $urandom_range(0, 99);
    px = 16'($urandom);
    py = 16'($urandom);
    t = (sel % 5 == 0) ? 17'($urandom) : 17'($urandom_range(0, 65536));
    if (known_x.size() > 0 && sel % 3 == 0) begin
      j = $urandom_range(0, known_x.size() - 1);
      px = known_x[j] + $signed(16'($urandom_range(0, 8))) - 16'sd4;
      py = known_y[j] + $signed(16'($urandom_range(0, 8))) - 16'sd4;
      if (sel % 2 == 0) begin
        px = known_x[j];
        py = known_y[j];
      end
    end
    if (sel < 2) send_item(KIND_CLEAR, px, py, t);
    else if (sel < 45) send_item(KIND_APPEND, px, py, t);
    else if (sel < 65) send_item(KIND_REMOVE, px, py, t);
    else send_item(KIND_EVAL, px, py, t);
  endtask

  initial begin
    logic [31:0] radii [5];
    radii = '{32'd0, 32'hFFFF_FFFF, 32'd4096, 32'd40000000, RADIUS_RESET};
    repeat (10) @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    // Directed: too few, extremes, duplicate, full list, removes, saturated t.
    send_item(KIND_EVAL, '0, '0, '0);
    send_item(KIND_APPEND, -16'sd32768, 16'sd32767, '0);
    send_item(KIND_EVAL, '0, '0, 17'd65536);
    send_item(KIND_APPEND, 16'sd32767, -16'sd32768, '0);
    send_item(KIND_APPEND, 16'sd32767, -16'sd32768, '0);
    send_item(KIND_EVAL, '0, '0, 17'd0);
    send_item(KIND_EVAL, '0, '0, 17'd65536);
    send_item(KIND_EVAL, '0, '0, 17'h1FFFF);
    send_item(KIND_EVAL, '0, '0, 17'd32768);
    send_item(KIND_REMOVE, 16'sd100, 16'sd100, '0);
    send_item(KIND_REMOVE, 16'sd32767, -16'sd32768, '0);
    for (int i = 0; i < 33; i++) send_item(KIND_APPEND, 16'(i * 1000), 16'(-i * 999), '0);
    send_item(KIND_EVAL, '0, '0, 17'd12345);
    send_item(KIND_CLEAR, 16'hFFFF, 16'hFFFF, 17'h1FFFF);
    send_item(KIND_EVAL, '0, '0, 17'd1);

    for (int ph = 0; ph < 5; ph++) begin
      write_radius(radii[ph]);
      for (int n = 0; n < 340; n++) begin
        if (ph == 1 && n == 50) hold_off = 400;
        if (ph == 2 && n == 100) drain_results();
        if (ph == 4 && n == 150) idle_on = 1'b0;
        random_item();
      end
    end

    drain_results();
    if (fail_count == 0) $display("bezier_curve_point_evaluator_core: match");
    else $display("bezier_curve_point_evaluator_core: mismatch");
    $finish;
  end

  initial begin
    #20ms;
    $display("bezier_curve_point_evaluator_core: mismatch");
    $finish;
  end

endmodule

`default_nettype wire

// ===== sim.f =====
sv/bcpe_pkg.sv
sv/bcpe_cell.sv
sv/bcpe_ctrl.sv
sv/bezier_curve_point_evaluator_core.sv
tb/bcpe_checker.sv
tb/tb_top.sv
